[design/lzwc_pkg.sv]
// ----------------------------------------------------------------------------
// lzwc_pkg: shared types and constants for the window copy decoder
// Holds the command/status structs between controller and datapath, and the
// offset-class functions that rebuild a 12-bit match distance.
// ----------------------------------------------------------------------------
`default_nettype none

package lzwc_pkg;

   localparam int unsigned WINDOW_AW = 12;

   localparam logic [WINDOW_AW:0] WINDOW_SIZE = 13'd4096;
   localparam logic [8:0]         LENGTH_BIAS = 9'd253;
   localparam logic [8:0]         RUN_LIMIT   = 9'd60;
   localparam logic [8:0]         LITERAL_END = 9'd256;
   localparam logic [7:0]         FILL_BYTE   = 8'h20;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;   // take the accepted word and set up its run
      logic rd;     // read the window at the current source index
      logic emit;   // produce one output byte and store it in the window
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic code_ok;     // incoming symbol is below the symbol count
      logic is_literal;  // incoming symbol is a literal byte
      logic last;        // the byte about to be produced ends the run
      logic out_free;    // the output register can take a byte this cycle
   } ctrl_status_type;

   // Number of extra offset bits that follow the first offset byte.
   function automatic logic [2:0] extra_count(input logic [7:0] b);
      logic [2:0] n;
      if (b < 8'h20)      n = 3'd1;
      else if (b < 8'h50) n = 3'd2;
      else if (b < 8'h90) n = 3'd3;
      else if (b < 8'hC0) n = 3'd4;
      else if (b < 8'hF0) n = 3'd5;
      else                n = 3'd6;
      return n;
   endfunction

   // Upper six distance bits, taken from the class of the first offset byte.
   function automatic logic [5:0] upper_modifier(input logic [7:0] b);
      logic [7:0] d;
      logic [5:0] m;
      d = 8'd0;
      if (b < 8'h20) begin
         m = 6'd0;
      end else if (b < 8'h50) begin
         d = b - 8'h20;
         m = 6'(d >> 4) + 6'd1;
      end else if (b < 8'h90) begin
         d = b - 8'h50;
         m = 6'(d >> 3) + 6'd4;
      end else if (b < 8'hC0) begin
         d = b - 8'h90;
         m = 6'(d >> 2) + 6'h0C;
      end else if (b < 8'hF0) begin
         d = b - 8'hC0;
         m = 6'(d >> 1) + 6'h18;
      end else begin
         d = b - 8'hC0;
         m = d[5:0];
      end
      return m;
   endfunction

   function automatic logic [WINDOW_AW-1:0] match_distance(input logic [7:0] first,
                                                           input logic [5:0] extra);
      logic [2:0]  n;
      logic [13:0] shifted;
      logic [5:0]  mask;
      logic [5:0]  low;
      n       = extra_count(first);
      shifted = {6'd0, first} << n;
      mask    = 6'((7'd1 << n) - 7'd1);
      low     = shifted[5:0] | (extra & mask);
      return {upper_modifier(first), low};
   endfunction

endpackage

`default_nettype wire

[design/lzwc_ctrl.sv]
// ----------------------------------------------------------------------------
// lzwc_ctrl: sequencer for the window copy decoder
// Accepts one word; a literal goes straight to its emit, a match alternates
// window reads and byte emits until the run is done, a bad symbol is dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module lzwc_ctrl (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   input  wire lzwc_pkg::ctrl_status_type status,
   output lzwc_pkg::ctrl_cmd_type        cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_READ = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      cmd        = '0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               if (!status.code_ok) begin
                  state_in = ST_IDLE;
               end else if (status.is_literal) begin
                  state_in = ST_EMIT;
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            cmd.rd   = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = status.last ? ST_IDLE : ST_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

[design/lzwc_datapath.sv]
// ----------------------------------------------------------------------------
// lzwc_datapath: window memory, run registers and output register
// Holds the 4096-byte ring window, the write index, a fill count that stands
// in for the reset fill, and the registered output byte.
// ----------------------------------------------------------------------------
`default_nettype none

module lzwc_datapath #(
   parameter int unsigned SYMBOL_COUNT = 314
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic [23:0]               req_tdata,
   input  wire lzwc_pkg::ctrl_cmd_type    cmd,
   output lzwc_pkg::ctrl_status_type      status,
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   output logic [7:0]                     rsp_tdata,
   output logic                           rsp_tlast
);

   localparam int unsigned AW = lzwc_pkg::WINDOW_AW;

   logic [8:0] symbol_code;
   logic [7:0] offset_first_byte;
   logic [5:0] offset_extra_bits;

   assign symbol_code       = req_tdata[8:0];
   assign offset_first_byte = req_tdata[16:9];
   assign offset_extra_bits = req_tdata[22:17];

   logic [7:0]    window_ff [0:(1 << AW)-1];
   logic [AW-1:0] wp_ff;
   logic [AW:0]   fill_ff;
   logic [AW-1:0] src_ff;
   logic [5:0]    count_ff;
   logic          lit_ff;
   logic [7:0]    lit_byte_ff;
   logic [7:0]    rd_data_ff;
   logic          rd_valid_ff;
   logic          rsp_valid_ff;
   logic [7:0]    rsp_data_ff;
   logic          rsp_last_ff;

   logic [8:0]    len_raw;
   logic [5:0]    run_len;
   logic [AW-1:0] src_in;
   logic [7:0]    byte_sel;

   assign len_raw = symbol_code - lzwc_pkg::LENGTH_BIAS;
   assign run_len = (len_raw > lzwc_pkg::RUN_LIMIT) ? lzwc_pkg::RUN_LIMIT[5:0] : len_raw[5:0];
   assign src_in  = wp_ff - lzwc_pkg::match_distance(offset_first_byte, offset_extra_bits)
                    - AW'(1);

   // Entries at or above the fill count have never been written since reset.
   assign byte_sel = lit_ff      ? lit_byte_ff :
                     rd_valid_ff ? rd_data_ff  : lzwc_pkg::FILL_BYTE;

   assign status.code_ok    = symbol_code < 9'(SYMBOL_COUNT);
   assign status.is_literal = symbol_code < lzwc_pkg::LITERAL_END;
   assign status.last       = count_ff == 6'd1;
   assign status.out_free   = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         window_ff[wp_ff] <= byte_sel;
      end
      if (cmd.rd) begin
         rd_data_ff  <= window_ff[src_ff];
         rd_valid_ff <= {1'b0, src_ff} < fill_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         src_ff      <= src_in;
         count_ff    <= status.is_literal ? 6'd1 : run_len;
         lit_ff      <= status.is_literal;
         lit_byte_ff <= symbol_code[7:0];
      end else if (cmd.emit) begin
         src_ff   <= src_ff + AW'(1);
         count_ff <= count_ff - 6'd1;
      end
      if (cmd.emit) begin
         rsp_data_ff <= byte_sel;
         rsp_last_ff <= status.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff        <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.emit) begin
            wp_ff <= wp_ff + AW'(1);
            if (fill_ff != lzwc_pkg::WINDOW_SIZE) begin
               fill_ff <= fill_ff + (AW+1)'(1);
            end
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

endmodule

`default_nettype wire

[design/lzhuf_window_copy_decoder.sv]
// ----------------------------------------------------------------------------
// lzhuf_window_copy_decoder: LZSS back end with a 4096-byte ring window
// Turns decoded symbols into bytes: literals pass through, matches copy a run
// of earlier bytes out of the window, each byte also written back.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake              Contents
//   req_     in         req_tvalid/req_tready  symbol code and match offset bits
//   rsp_     out        rsp_tvalid/rsp_tready  one decoded byte, tlast ends run
//
// A literal goes straight to its emit step; every match byte is a window read
// followed by an emit that writes it back through the single memory port pair,
// and no new word is taken until the run is done.
// A symbol at or above SYMBOL_COUNT is dropped in its acceptance cycle.
// Reset clears the write index and a fill count; window entries not yet
// written read as spaces, so no clearing pass is needed after reset.
// A stalled output holds the emit step; a new word is taken while the last
// byte of the previous run still waits in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lzhuf_window_copy_decoder #(
   parameter int unsigned SYMBOL_COUNT = 314
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [8:0] symbol_code, [16:9] offset_first_byte, [22:17] offset_extra_bits,
   // [23] zero fill
   input  wire logic [23:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [7:0] out_byte
   output logic [7:0]       rsp_tdata,
   output logic             rsp_tlast
);

   lzwc_pkg::ctrl_cmd_type    cmd;
   lzwc_pkg::ctrl_status_type status;

   // The controller walks each word through load, read and emit steps; a literal skips the read.
   lzwc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // The datapath owns the window, the run counters and the output register.
   lzwc_datapath #(
      .SYMBOL_COUNT (SYMBOL_COUNT)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // A byte is only produced when the output register has room for it.
   a_emit_room: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_tvalid || rsp_tready))
      else $error("byte emitted into a full output register");

   // A dropped symbol leaves the block ready for the next word.
   a_drop_idle: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && !status.code_ok) |=> req_tready)
      else $error("out-of-range symbol did not return to idle");

   // The final byte of a run hands control back to the input side.
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && status.last) |=> (req_tready && rsp_tvalid && rsp_tlast))
      else $error("run end not followed by idle with tlast shown");

   // No word is taken while a run is still being produced.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      (cmd.rd || cmd.emit) |-> !req_tready)
      else $error("input ready during a run");

endmodule

`default_nettype wire
